// ===== hw/rtl/cymbal_hit_choke_detector_unit_macros.svh =====
// Assertion macros shared by the cymbal hit and choke detector RTL.
`ifndef CYMBAL_HIT_CHOKE_DETECTOR_UNIT_MACROS_SVH
`define CYMBAL_HIT_CHOKE_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CHCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cymbal detector check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CHCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cymbal detector sequence check failed");

`endif

// ===== hw/rtl/chcd_pkg.sv =====
// Package with the constants and codes of the cymbal hit and choke detector.
package chcd_pkg;

  // Configuration port widths.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // Configuration register indices.
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIEZO_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_THRESHOLD  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CUP_THRESHOLD   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCAN_TIME_US    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MASK_TIME_MS    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHOKE_MODE      = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZONE_COUNT      = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHARED_TRS      = 3'd7;

  // Detector phases.
  localparam logic [1:0] PH_DETECT = 2'd0;
  localparam logic [1:0] PH_SCAN   = 2'd1;
  localparam logic [1:0] PH_MASK   = 2'd2;

  // Last reported event.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_HIT   = 2'd1;
  localparam logic [1:0] EV_CHOKE = 2'd2;

  // Choke switch selection; the spare code selects no choke switch.
  localparam logic [1:0] CHOKE_NONE  = 2'd0;
  localparam logic [1:0] CHOKE_EDGE  = 2'd1;
  localparam logic [1:0] CHOKE_CUP   = 2'd2;
  localparam logic [1:0] CHOKE_SPARE = 2'd3;

  // Hit zones.
  localparam logic [1:0] ZONE_BOW  = 2'd0;
  localparam logic [1:0] ZONE_EDGE = 2'd1;
  localparam logic [1:0] ZONE_CUP  = 2'd2;

  // Zone count codes.
  localparam logic [1:0] ZC_NONE  = 2'd0;
  localparam logic [1:0] ZC_ONE   = 2'd1;
  localparam logic [1:0] ZC_TWO   = 2'd2;
  localparam logic [1:0] ZC_THREE = 2'd3;

  // Millisecond to microsecond conversion for the mask window.
  localparam int               MASK_US_BITS = 18;
  localparam logic [MASK_US_BITS-1:0] US_PER_MS = 18'd1000;

  // Switch press counters.
  localparam int               COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_SCAN_TIME_US = 16'd2000;
  localparam logic [7:0]  RST_MASK_TIME_MS = 8'd30;

endpackage

// ===== hw/rtl/cymbal_hit_choke_detector_unit.sv =====
// Top level of the cymbal hit and choke detector: one result item per sample item.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_stall  | time_us, connected, piezo/edge/cup_sample
//   out     | output    | out_valid / out_stall| hit, hit_zone, peak_value, choked
//   cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// The state update and the result are worked out in one pass from the accepted item and land
// in the state registers and the result register together.
// An item is accepted every cycle unless a result sits in the result register and is stalled.
// Reset is synchronous: phase returns to peak detect, counters and times clear, the
// configuration registers take their reset values and the result register empties.
`include "cymbal_hit_choke_detector_unit_macros.svh"

module cymbal_hit_choke_detector_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port
  input  logic                                 cfg_write,
  input  logic [chcd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [chcd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [31:0]                          time_us,
  input  logic                                 connected,
  input  logic [SAMPLE_BITS-1:0]               piezo_sample,
  input  logic [SAMPLE_BITS-1:0]               edge_sample,
  input  logic [SAMPLE_BITS-1:0]               cup_sample,
  // Output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 hit,
  output logic [1:0]                           hit_zone,
  output logic [SAMPLE_BITS-1:0]               peak_value,
  output logic                                 choked
);

  localparam int CB = chcd_pkg::COUNT_BITS;
  localparam int MB = chcd_pkg::MASK_US_BITS;

  // Configuration registers
  logic [SAMPLE_BITS-1:0] piezo_threshold;
  logic [SAMPLE_BITS-1:0] edge_threshold;
  logic [SAMPLE_BITS-1:0] cup_threshold;
  logic [15:0]            scan_time_us;
  logic [7:0]             mask_time_ms;
  logic [1:0]             choke_mode;
  logic [1:0]             zone_count;
  logic                   shared_trs;

  // Detector state
  logic [1:0]             phase, phase_next;
  logic [31:0]            hit_start_time, hit_start_time_next;
  logic [31:0]            scan_end_time, scan_end_time_next;
  logic [SAMPLE_BITS-1:0] peak_level, peak_level_next;
  logic [CB-1:0]          edge_press_count, edge_press_count_next;
  logic [CB-1:0]          cup_press_count, cup_press_count_next;
  logic [1:0]             last_event, last_event_next;

  // Result values for the accepted item
  logic                   hit_next;
  logic [1:0]             hit_zone_next;
  logic [SAMPLE_BITS-1:0] peak_value_next;
  logic                   choked_next;

  // Working signals
  logic                   in_accept;
  logic [SAMPLE_BITS-1:0] edge_level, cup_level;
  logic                   zc_edge_on, zc_cup_on;
  logic                   edge_pressed, cup_pressed, piezo_over, choke_hit;
  logic [SAMPLE_BITS-1:0] track_peak;
  logic [CB-1:0]          edge_inc, cup_inc, track_edge, track_cup;
  logic [31:0]            scan_elapsed, mask_elapsed;
  logic [MB-1:0]          mask_limit_us;

  // The result register frees up when it is empty or its item is taken this cycle.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      piezo_threshold <= SAMPLE_BITS'(100);
      edge_threshold  <= SAMPLE_BITS'(2048);
      cup_threshold   <= SAMPLE_BITS'(2048);
      scan_time_us    <= chcd_pkg::RST_SCAN_TIME_US;
      mask_time_ms    <= chcd_pkg::RST_MASK_TIME_MS;
      choke_mode      <= chcd_pkg::CHOKE_NONE;
      zone_count      <= chcd_pkg::ZC_THREE;
      shared_trs      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        chcd_pkg::REG_PIEZO_THRESHOLD: piezo_threshold <= cfg_data[SAMPLE_BITS-1:0];
        chcd_pkg::REG_EDGE_THRESHOLD:  edge_threshold  <= cfg_data[SAMPLE_BITS-1:0];
        chcd_pkg::REG_CUP_THRESHOLD:   cup_threshold   <= cfg_data[SAMPLE_BITS-1:0];
        chcd_pkg::REG_SCAN_TIME_US:    scan_time_us    <= cfg_data[15:0];
        chcd_pkg::REG_MASK_TIME_MS:    mask_time_ms    <= cfg_data[7:0];
        chcd_pkg::REG_CHOKE_MODE:      choke_mode      <= cfg_data[1:0];
        chcd_pkg::REG_ZONE_COUNT:      zone_count      <= cfg_data[1:0];
        chcd_pkg::REG_SHARED_TRS:      shared_trs      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Switch levels: in shared mode the edge pin is split at the cup threshold.
  always_comb begin
    edge_level = edge_sample;
    cup_level  = cup_sample;
    if (shared_trs) begin
      if (edge_sample >= cup_threshold) begin
        cup_level  = edge_sample;
        edge_level = '0;
      end else begin
        cup_level  = '0;
      end
    end
  end

  // Active switches; a zone count of zero counts as the piezo alone.
  assign zc_edge_on = (zone_count != chcd_pkg::ZC_NONE) && (zone_count != chcd_pkg::ZC_ONE);
  assign zc_cup_on  = (zone_count == chcd_pkg::ZC_THREE);

  assign edge_pressed = zc_edge_on && (edge_level >= edge_threshold);
  assign cup_pressed  = zc_cup_on && (cup_level >= cup_threshold);
  assign piezo_over   = piezo_sample >= piezo_threshold;

  // The choke switch only counts when its zone is active.
  always_comb begin
    case (choke_mode)
      chcd_pkg::CHOKE_EDGE: choke_hit = edge_pressed;
      chcd_pkg::CHOKE_CUP:  choke_hit = cup_pressed;
      default:              choke_hit = 1'b0;
    endcase
  end

  // Saturating press counters and the running peak during a scan.
  assign edge_inc   = (edge_press_count == chcd_pkg::COUNT_MAX) ? edge_press_count
                                                              : edge_press_count + 1'b1;
  assign cup_inc    = (cup_press_count == chcd_pkg::COUNT_MAX) ? cup_press_count
                                                             : cup_press_count + 1'b1;
  assign track_edge = edge_pressed ? edge_inc : edge_press_count;
  assign track_cup  = cup_pressed ? cup_inc : cup_press_count;
  assign track_peak = (piezo_over && (piezo_sample > peak_level)) ? piezo_sample : peak_level;

  // Elapsed times wrap modulo 2^32; the mask length is converted to microseconds.
  assign scan_elapsed  = time_us - hit_start_time;
  assign mask_elapsed  = time_us - scan_end_time;
  assign mask_limit_us = MB'(mask_time_ms) * chcd_pkg::US_PER_MS;

  // Next state and result of the accepted item.
  always_comb begin
    phase_next            = phase;
    hit_start_time_next   = hit_start_time;
    scan_end_time_next    = scan_end_time;
    peak_level_next       = peak_level;
    edge_press_count_next = edge_press_count;
    cup_press_count_next  = cup_press_count;
    last_event_next       = last_event;
    hit_next              = 1'b0;
    hit_zone_next         = chcd_pkg::ZONE_BOW;
    peak_value_next       = '0;
    choked_next           = 1'b0;
    if (connected) begin
      case (phase)
        chcd_pkg::PH_DETECT: begin
          // A scan opens on a piezo strike or a choke press, with fresh counters.
          if (piezo_over || choke_hit) begin
            hit_start_time_next   = time_us;
            peak_level_next       = (piezo_over && (piezo_sample != '0)) ? piezo_sample : '0;
            edge_press_count_next = edge_pressed ? CB'(1) : '0;
            cup_press_count_next  = cup_pressed ? CB'(1) : '0;
            phase_next            = chcd_pkg::PH_SCAN;
          end
        end
        chcd_pkg::PH_SCAN: begin
          peak_level_next       = track_peak;
          edge_press_count_next = track_edge;
          cup_press_count_next  = track_cup;
          if (scan_elapsed >= {16'd0, scan_time_us}) begin
            scan_end_time_next = time_us;
            if (track_peak == '0) begin
              // No strike: report a choke unless the last event already was one.
              if (last_event != chcd_pkg::EV_CHOKE) begin
                choked_next     = 1'b1;
                last_event_next = chcd_pkg::EV_CHOKE;
                phase_next      = chcd_pkg::PH_MASK;
              end else begin
                phase_next = chcd_pkg::PH_DETECT;
              end
            end else begin
              hit_next        = 1'b1;
              peak_value_next = track_peak;
              last_event_next = chcd_pkg::EV_HIT;
              phase_next      = chcd_pkg::PH_MASK;
              // The switch with most presses wins, edge on a tie, else the bow.
              if (zc_cup_on && (track_cup > track_edge)) begin
                hit_zone_next = chcd_pkg::ZONE_CUP;
              end else if (zc_edge_on && (track_edge != '0)) begin
                hit_zone_next = chcd_pkg::ZONE_EDGE;
              end else begin
                hit_zone_next = chcd_pkg::ZONE_BOW;
              end
            end
          end
        end
        default: begin
          // Retrigger mask after a report.
          if (mask_elapsed >= {{(32-MB){1'b0}}, mask_limit_us}) begin
            phase_next = chcd_pkg::PH_DETECT;
          end
        end
      endcase
    end
  end

  // Detector state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= chcd_pkg::PH_DETECT;
      hit_start_time   <= '0;
      scan_end_time    <= '0;
      peak_level       <= '0;
      edge_press_count <= '0;
      cup_press_count  <= '0;
      last_event       <= chcd_pkg::EV_NONE;
    end else if (in_accept) begin
      phase            <= phase_next;
      hit_start_time   <= hit_start_time_next;
      scan_end_time    <= scan_end_time_next;
      peak_level       <= peak_level_next;
      edge_press_count <= edge_press_count_next;
      cup_press_count  <= cup_press_count_next;
      last_event       <= last_event_next;
    end
  end

  // Result register: loads on every accepted item, empties when its item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hit        <= hit_next;
      hit_zone   <= hit_zone_next;
      peak_value <= peak_value_next;
      choked     <= choked_next;
    end
  end

  // Checks on the detector logic
  `CHCD_ASSERT_NOW(a_hit_choke_exclusive, out_valid, !(hit && choked))
  `CHCD_ASSERT_NOW(a_no_hit_zero_payload, out_valid && !hit,
                   (hit_zone == chcd_pkg::ZONE_BOW) && (peak_value == '0))
  `CHCD_ASSERT_NOW(a_hit_has_peak, out_valid && hit, peak_value != '0)
  `CHCD_ASSERT_NEXT(a_accept_fills_result, in_accept, out_valid)
  `CHCD_ASSERT_NEXT(a_report_enters_mask, in_accept && (hit_next || choked_next),
                    phase == chcd_pkg::PH_MASK)

endmodule
